/* src/nosc_pkg.sv */
// shared types and constants for the natural order string compare block
package nosc_pkg;
    localparam int MaxChars = 256;
    localparam int AddrW = $clog2(MaxChars);
    localparam int LenW = AddrW + 1;
    localparam logic [7:0] CharZero = 8'h30;
    localparam logic [7:0] CharNine = 8'h39;
    localparam logic [7:0] CharUpA = 8'h41;
    localparam logic [7:0] CharUpZ = 8'h5a;
    localparam logic [7:0] FoldOff = 8'h20;
    localparam logic [1:0] OrdLess = 2'b11;
    localparam logic [1:0] OrdEq = 2'b00;
    localparam logic [1:0] OrdMore = 2'b01;
    localparam logic [0:0] RegCaseSens = 1'b0;

    typedef enum logic [3:0] {
        CMD_NONE = 4'd0,
        CMD_PREFIX = 4'd1,
        CMD_BACK = 4'd2,
        CMD_ZA = 4'd3,
        CMD_NA = 4'd4,
        CMD_ZB = 4'd5,
        CMD_NB = 4'd6,
        CMD_DIG = 4'd7,
        CMD_RESTART = 4'd8
    } t_op;

    typedef struct packed {
        t_op op;
        logic rd;
    } t_cmd;

    typedef struct packed {
        logic [7:0] ca;
        logic [7:0] cb;
        logic a_ok;
        logic b_ok;
        logic prev_dig;
        logic digit_eq;
        logic [1:0] ord_num;
    } t_status;

    function automatic logic is_dig(input logic [7:0] c);
        return (c >= CharZero) && (c <= CharNine);
    endfunction

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        if (!cs && c >= CharUpA && c <= CharUpZ)
            return c + FoldOff;
        return c;
    endfunction

    function automatic logic [1:0] cmp8(input logic [7:0] x, input logic [7:0] y);
        if (x > y) return OrdMore;
        if (x < y) return OrdLess;
        return OrdEq;
    endfunction
endpackage

/* src/nosc_if.sv */
// valid/ready channel interfaces for load beats and results
interface nosc_in_if;
    logic valid;
    logic ready;
    logic [7:0] a_char;
    logic a_present;
    logic [7:0] b_char;
    logic b_present;
    logic last_pair;
    modport source(output valid, a_char, a_present, b_char, b_present, last_pair, input ready);
    modport sink(input valid, a_char, a_present, b_char, b_present, last_pair, output ready);
endinterface

interface nosc_out_if;
    logic valid;
    logic ready;
    logic signed [1:0] order;
    logic overflow;
    modport source(output valid, order, overflow, input ready);
    modport sink(input valid, order, overflow, output ready);
endinterface

/* src/natural_order_string_compare.sv */
// natural order string compare: top level with apb register and channels
// Loads one pair of bytes per cycle; from the last pair until its result is
// taken no input is accepted. The controller walks the stores through one
// registered memory read per cycle: the common prefix, a back-up over a shared
// digit run, leading zeros and digits of each number, then the digits
// pairwise. Capacity is 256 bytes per string; extra bytes set overflow.
module natural_order_string_compare (
    input  logic i_clk,
    input  logic i_rst_n,
    nosc_in_if.sink i_in,
    nosc_out_if.source o_out,
    input  logic psel,
    input  logic penable,
    input  logic pwrite,
    input  logic [2:0] paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    import nosc_pkg::*;

    logic r_cs;
    logic load;
    t_cmd cmd;
    t_status st;
    logic trunc;
    logic [1:0] ord;

    assign pready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_cs <= 1'b1;
        else if (psel && penable && pwrite && paddr[2] == RegCaseSens)
            r_cs <= pwdata[0];
    end
    assign prdata = (paddr[2] == RegCaseSens) ? {31'd0, r_cs} : 32'd0;

    nosc_ctrl u_ctrl (
        .i_clk, .i_rst_n, .i_cs(r_cs),
        .i_in_valid(i_in.valid), .i_last(i_in.last_pair), .o_in_ready(i_in.ready),
        .o_load(load), .o_cmd(cmd), .i_st(st), .i_trunc(trunc),
        .o_out_valid(o_out.valid), .i_out_ready(o_out.ready),
        .o_order(ord), .o_overflow(o_out.overflow)
    );
    assign o_out.order = ord;

    nosc_dp u_dp (
        .i_clk, .i_rst_n, .i_load(load),
        .i_a_char(i_in.a_char), .i_a_present(i_in.a_present),
        .i_b_char(i_in.b_char), .i_b_present(i_in.b_present),
        .i_cmd(cmd), .o_st(st), .o_trunc(trunc)
    );
endmodule

/* src/nosc_dp.sv */
// datapath: string stores, lengths, pointers and counters
module nosc_dp (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_load,
    input  logic [7:0] i_a_char,
    input  logic i_a_present,
    input  logic [7:0] i_b_char,
    input  logic i_b_present,
    input  nosc_pkg::t_cmd i_cmd,
    output nosc_pkg::t_status o_st,
    output logic o_trunc
);
    import nosc_pkg::*;

    logic [7:0] r_mem_a [MaxChars];
    logic [7:0] r_mem_b [MaxChars];
    logic [LenW-1:0] r_la, r_lb, r_pa, r_pb, r_na, r_nb, r_za, r_zb;
    logic r_trunc;
    logic [7:0] r_ca, r_cb;
    logic r_a_ok, r_b_ok, r_prev_ok;
    logic [LenW-1:0] n_ra, n_rb;
    logic [LenW-1:0] r_i;

    // read at the pointer values that hold after this step; CMD_BACK reads at i - 1
    always_comb begin
        n_ra = r_pa;
        n_rb = r_pb;
        case (i_cmd.op)
            CMD_BACK: begin n_ra = r_i - 1'b1; n_rb = r_i - 1'b1; end
            CMD_PREFIX: begin
                if (i_cmd.rd) begin n_ra = r_pa + 1'b1; n_rb = r_pb + 1'b1; end
            end
            CMD_ZA, CMD_NA: begin
                if (i_cmd.rd) n_ra = r_pa + 1'b1;
            end
            CMD_ZB: begin
                if (i_cmd.rd) n_rb = r_pb + 1'b1;
                else n_ra = r_pa - r_na;
            end
            CMD_NB: begin
                if (i_cmd.rd) n_rb = r_pb + 1'b1;
            end
            CMD_DIG: begin
                if (i_cmd.rd) begin n_ra = r_pa + 1'b1; n_rb = r_pb + 1'b1; end
                else n_rb = r_pb - r_nb;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_a_present && r_la < LenW'(MaxChars))
            r_mem_a[r_la[AddrW-1:0]] <= i_a_char;
        if (i_load && i_b_present && r_lb < LenW'(MaxChars))
            r_mem_b[r_lb[AddrW-1:0]] <= i_b_char;
        r_ca <= r_mem_a[n_ra[AddrW-1:0]];
        r_cb <= r_mem_b[n_rb[AddrW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_la <= '0; r_lb <= '0; r_trunc <= 1'b0;
            r_pa <= '0; r_pb <= '0; r_i <= '0;
            r_na <= '0; r_nb <= '0; r_za <= '0; r_zb <= '0;
            r_a_ok <= 1'b0; r_b_ok <= 1'b0; r_prev_ok <= 1'b0;
        end else begin
            r_a_ok <= n_ra < r_la;
            r_b_ok <= n_rb < r_lb;
            r_prev_ok <= (i_cmd.op == CMD_BACK) && (r_i != '0);
            if (i_load) begin
                if (i_a_present) begin
                    if (r_la < LenW'(MaxChars)) r_la <= r_la + 1'b1;
                    else r_trunc <= 1'b1;
                end
                if (i_b_present) begin
                    if (r_lb < LenW'(MaxChars)) r_lb <= r_lb + 1'b1;
                    else r_trunc <= 1'b1;
                end
            end
            // i_cmd.rd means the registered chars reflect the previous addresses
            if (i_cmd.rd) begin
                case (i_cmd.op)
                    CMD_PREFIX: begin
                        r_pa <= r_pa + 1'b1; r_pb <= r_pb + 1'b1; r_i <= r_pa + 1'b1;
                    end
                    CMD_BACK: r_i <= r_i - 1'b1;
                    CMD_ZA: begin r_pa <= r_pa + 1'b1; r_za <= r_za + 1'b1; end
                    CMD_NA: begin r_pa <= r_pa + 1'b1; r_na <= r_na + 1'b1; end
                    CMD_ZB: begin r_pb <= r_pb + 1'b1; r_zb <= r_zb + 1'b1; end
                    CMD_NB: begin r_pb <= r_pb + 1'b1; r_nb <= r_nb + 1'b1; end
                    CMD_DIG: begin r_pa <= r_pa + 1'b1; r_pb <= r_pb + 1'b1; end
                    default: ;
                endcase
            end else begin
                case (i_cmd.op)
                    CMD_BACK: begin r_pa <= r_i; r_pb <= r_i; end
                    CMD_ZB: begin r_pa <= r_pa - r_na; end
                    CMD_DIG: begin r_pb <= r_pb - r_nb; end
                    CMD_RESTART: begin
                        r_la <= '0; r_lb <= '0; r_trunc <= 1'b0;
                        r_pa <= '0; r_pb <= '0; r_i <= '0;
                        r_na <= '0; r_nb <= '0; r_za <= '0; r_zb <= '0;
                    end
                    default: ;
                endcase
            end
        end
    end

    assign o_st.ca = r_ca;
    assign o_st.cb = r_cb;
    assign o_st.a_ok = r_a_ok;
    assign o_st.b_ok = r_b_ok;
    assign o_st.prev_dig = r_prev_ok && is_dig(r_ca);
    assign o_st.digit_eq = (r_na == r_nb);
    assign o_st.ord_num = (r_na != r_nb) ? ((r_na > r_nb) ? OrdMore : OrdLess)
                        : ((r_za > r_zb) ? OrdMore : ((r_za < r_zb) ? OrdLess : OrdEq));
    assign o_trunc = r_trunc;
endmodule

/* src/nosc_ctrl.sv */
// controller: load handshake, compare sequencing and result register
module nosc_ctrl (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cs,
    input  logic i_in_valid,
    input  logic i_last,
    output logic o_in_ready,
    output logic o_load,
    output nosc_pkg::t_cmd o_cmd,
    input  nosc_pkg::t_status i_st,
    input  logic i_trunc,
    output logic o_out_valid,
    input  logic i_out_ready,
    output logic [1:0] o_order,
    output logic o_overflow
);
    import nosc_pkg::*;

    typedef enum logic [9:0] {
        S_LOAD = 10'b0000000001,
        S_PRE  = 10'b0000000010,
        S_BACK = 10'b0000000100,
        S_ZA   = 10'b0000001000,
        S_NA   = 10'b0000010000,
        S_ZB   = 10'b0000100000,
        S_NB   = 10'b0001000000,
        S_DIG  = 10'b0010000000,
        S_DONE = 10'b0100000000,
        S_OUT  = 10'b1000000000
    } t_state;

    t_state r_state, n_state;
    logic r_rd, n_rd;
    logic [1:0] r_ord, n_ord;
    logic r_ovf;
    logic r_bdone, n_bdone;
    logic [7:0] fa, fb;
    logic a_dig, b_dig;

    assign fa = fold(i_st.ca, i_cs);
    assign fb = fold(i_st.cb, i_cs);
    assign a_dig = i_st.a_ok && is_dig(i_st.ca);
    assign b_dig = i_st.b_ok && is_dig(i_st.cb);

    assign o_in_ready = (r_state == S_LOAD) || (r_state == S_OUT && i_out_ready) ? 1'b1 : 1'b0;
    assign o_load = i_in_valid && o_in_ready;
    assign o_out_valid = (r_state == S_OUT);
    assign o_order = r_ord;
    assign o_overflow = r_ovf;

    always_comb begin
        n_state = r_state;
        n_rd = 1'b0;
        n_ord = r_ord;
        n_bdone = r_bdone;
        o_cmd.op = CMD_NONE;
        o_cmd.rd = r_rd;
        case (r_state)
            S_LOAD: begin
                if (o_load && i_last) begin n_state = S_PRE; n_bdone = 1'b0; end
            end
            S_OUT: begin
                if (i_out_ready) begin
                    n_state = (o_load && i_last) ? S_PRE : S_LOAD;
                    n_bdone = 1'b0;
                end
            end
            S_PRE: begin
                o_cmd.op = CMD_PREFIX;
                n_rd = 1'b1;
                if (r_rd && !(i_st.a_ok && i_st.b_ok && fa == fb)) begin
                    o_cmd.op = CMD_NONE;
                    n_rd = 1'b0;
                    if (!a_dig && !b_dig) begin
                        if (!i_st.a_ok) n_ord = i_st.b_ok ? OrdLess : OrdEq;
                        else if (!i_st.b_ok) n_ord = OrdMore;
                        else n_ord = cmp8(fa, fb);
                        n_state = S_DONE;
                    end else n_state = S_BACK;
                end
            end
            S_BACK: begin
                // read the char before i; step back while it is a digit
                o_cmd.op = CMD_BACK;
                n_rd = 1'b1;
                if (r_rd) begin
                    if (i_st.prev_dig) begin
                        n_bdone = 1'b1;
                        n_rd = 1'b0;
                    end else begin
                        o_cmd.op = CMD_NONE;
                        n_rd = 1'b0;
                        n_state = S_ZA;
                    end
                end
            end
            S_ZA: begin
                o_cmd.op = CMD_ZA;
                n_rd = 1'b1;
                if (r_rd && !r_bdone) begin
                    // no back-up: prefix reached end of shorter string?
                    if (!(i_st.a_ok && i_st.b_ok)) begin
                        o_cmd.op = CMD_NONE; n_rd = 1'b0;
                        n_ord = !i_st.a_ok ? (i_st.b_ok ? OrdLess : OrdEq) : OrdMore;
                        n_state = S_DONE;
                    end else if (!is_dig(i_st.ca) || !is_dig(i_st.cb)) begin
                        o_cmd.op = CMD_NONE; n_rd = 1'b0;
                        n_ord = cmp8(fa, fb);
                        n_state = S_DONE;
                    end else begin
                        n_bdone = 1'b1;
                        o_cmd.op = CMD_NONE; n_rd = 1'b0;
                    end
                end else if (r_rd && r_bdone == 1'b1 && i_st.a_ok && i_st.ca == CharZero) begin
                    n_rd = 1'b1;
                end else if (r_rd) begin
                    o_cmd.op = CMD_NA; n_state = S_NA;
                    if (!a_dig) begin o_cmd.op = CMD_NONE; n_rd = 1'b0; n_state = S_ZB; end
                end
            end
            S_NA: begin
                o_cmd.op = CMD_NA;
                n_rd = 1'b1;
                if (r_rd && !a_dig) begin o_cmd.op = CMD_NONE; n_rd = 1'b0; n_state = S_ZB; end
            end
            S_ZB: begin
                o_cmd.op = CMD_ZB;
                n_rd = 1'b1;
                if (r_rd && !(i_st.b_ok && i_st.cb == CharZero)) begin
                    o_cmd.op = CMD_NB; n_state = S_NB;
                    if (!b_dig) begin o_cmd.op = CMD_NONE; n_rd = 1'b0; n_state = S_DIG; end
                end
            end
            S_NB: begin
                o_cmd.op = CMD_NB;
                n_rd = 1'b1;
                if (r_rd && !b_dig) begin o_cmd.op = CMD_NONE; n_rd = 1'b0; n_state = S_DIG; end
            end
            S_DIG: begin
                o_cmd.op = CMD_DIG;
                n_rd = 1'b1;
                if (!i_st.digit_eq) begin
                    o_cmd.op = CMD_NONE; n_rd = 1'b0;
                    n_ord = i_st.ord_num; n_state = S_DONE;
                end else if (r_rd) begin
                    if (!a_dig) begin
                        o_cmd.op = CMD_NONE; n_rd = 1'b0;
                        n_ord = i_st.ord_num; n_state = S_DONE;
                    end else if (i_st.ca != i_st.cb) begin
                        o_cmd.op = CMD_NONE; n_rd = 1'b0;
                        n_ord = cmp8(i_st.ca, i_st.cb); n_state = S_DONE;
                    end
                end
            end
            S_DONE: begin
                o_cmd.op = CMD_RESTART;
                o_cmd.rd = 1'b0;
                n_state = S_OUT;
            end
            default: n_state = S_LOAD;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD; r_rd <= 1'b0; r_ord <= OrdEq; r_ovf <= 1'b0; r_bdone <= 1'b0;
        end else begin
            r_state <= n_state; r_rd <= n_rd; r_ord <= n_ord; r_bdone <= n_bdone;
            if (r_state == S_DONE) r_ovf <= i_trunc;
        end
    end

    a_ready_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && !i_out_ready |=> o_out_valid)
        else $error("result dropped");
    a_no_load_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIG) |-> !o_in_ready)
        else $error("load during compare");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DONE) |=> o_out_valid)
        else $error("result missing");
endmodule
